[rtl/sorted_timer_list_top_defines.svh]
// ----------------------------------------------------------------------------
// Sorted timer list assertion macros
// Shared concurrent assertion wrappers, sampled on clk, disabled in rst.
// ----------------------------------------------------------------------------
`ifndef SORTED_TIMER_LIST_TOP_DEFINES_SVH
`define SORTED_TIMER_LIST_TOP_DEFINES_SVH

// plain property check
`define STL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// same-cycle implication
`define STL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

[rtl/stl_pkg.sv]
// ----------------------------------------------------------------------------
// Sorted timer list package
// Operation and status codes, controller/datapath command and status types.
// ----------------------------------------------------------------------------
package stl_pkg;

  localparam logic [1:0] OP_SORTED = 2'd0;
  localparam logic [1:0] OP_TAIL   = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_QUERY  = 2'd3;

  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_LINKED   = 2'd1;
  localparam logic [1:0] ST_UNLINKED = 2'd2;

  typedef struct packed {
    logic load;
    logic clr;
    logic rm;
    logic set_lnk;
    logic set_unl;
    logic key_wr;
    logic tail_set;
    logic walk_start;
    logic walk_step;
    logic spl1;
    logic spl2;
    logic out_load;
  } stl_cmd_t;

  typedef struct packed {
    logic is_query;
    logic node_bad;
    logic is_remove;
    logic is_tail;
    logic linked;
    logic walk_stop;
    logic clr_last;
    logic out_free;
  } stl_sts_t;

endpackage

[rtl/stl_ram.sv]
// ----------------------------------------------------------------------------
// Sorted timer list RAM
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module stl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/stl_ctrl.sv]
// ----------------------------------------------------------------------------
// Sorted timer list controller
// Sequences clear pass, lookup, walk, splice/unlink and result handoff.
// ----------------------------------------------------------------------------
module stl_ctrl
  import stl_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  stl_sts_t sts,
  output stl_cmd_t cmd
);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_LOOK = 3'd2;
  localparam logic [2:0] S_CHK  = 3'd3;
  localparam logic [2:0] S_WALK = 3'd4;
  localparam logic [2:0] S_SPL1 = 3'd5;
  localparam logic [2:0] S_SPL2 = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_CLR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        if (sts.is_query || sts.node_bad) begin
          state_next = S_DONE;
        end else begin
          state_next = S_CHK;
        end
      end
      S_CHK: begin
        if (sts.is_remove) begin
          if (sts.linked) begin
            cmd.rm = 1'b1;
          end else begin
            cmd.set_unl = 1'b1;
          end
          state_next = S_DONE;
        end else if (sts.linked) begin
          cmd.set_lnk = 1'b1;
          state_next  = S_DONE;
        end else begin
          cmd.key_wr = 1'b1;
          if (sts.is_tail) begin
            cmd.tail_set = 1'b1;
            state_next   = S_SPL1;
          end else begin
            cmd.walk_start = 1'b1;
            state_next     = S_WALK;
          end
        end
      end
      S_WALK: begin
        if (sts.walk_stop) begin
          state_next = S_SPL1;
        end else begin
          cmd.walk_step = 1'b1;
        end
      end
      S_SPL1: begin
        cmd.spl1   = 1'b1;
        state_next = S_SPL2;
      end
      S_SPL2: begin
        cmd.spl2   = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLR;
      end
    endcase
  end

endmodule

[rtl/stl_dp.sv]
// ----------------------------------------------------------------------------
// Sorted timer list datapath
// Link, key and linked-flag RAMs, head pointers, walk cursor, result register.
// ----------------------------------------------------------------------------
`include "sorted_timer_list_top_defines.svh"

module stl_dp
  import stl_pkg::*;
#(
  parameter int NODES     = 32,
  parameter int KEY_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  stl_cmd_t    cmd,
  output stl_sts_t    sts,
  input  logic [1:0]  in_op,
  input  logic [4:0]  in_node,
  input  logic [31:0] in_key,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic        out_empty
);

  localparam int IDX_W  = $clog2(NODES);
  localparam int LINK_W = $clog2(NODES + 1);
  localparam logic [LINK_W-1:0] HEAD = LINK_W'(NODES);

  function automatic logic [LINK_W-1:0] link_ok(input logic [LINK_W-1:0] v);
    link_ok = (v > HEAD) ? HEAD : v;
  endfunction

  logic [1:0]           op_r;
  logic [IDX_W-1:0]     n_r;
  logic                 node_bad_r;
  logic [KEY_WIDTH-1:0] key_r;
  logic [LINK_W-1:0]    at_r;
  logic [LINK_W-1:0]    cur_r;
  logic [LINK_W-1:0]    head_first;
  logic [LINK_W-1:0]    head_last;
  logic [1:0]           status_r;
  logic [IDX_W-1:0]     clr_cnt;

  logic [63:0]          key_ext;
  logic [31:0]          node_ext;
  logic                 node_bad_in;
  logic [LINK_W-1:0]    n_link;

  logic [LINK_W-1:0]    nxt_q;
  logic [LINK_W-1:0]    prv_q;
  logic [KEY_WIDTH-1:0] key_q;
  logic [0:0]           lnk_q;
  logic [LINK_W-1:0]    nxt_ok;
  logic [LINK_W-1:0]    a_link;
  logic [LINK_W-1:0]    b_link;

  logic [IDX_W-1:0]     raddr;
  logic                 nxt_we;
  logic [IDX_W-1:0]     nxt_waddr;
  logic [LINK_W-1:0]    nxt_wdata;
  logic                 prv_we;
  logic [IDX_W-1:0]     prv_waddr;
  logic [LINK_W-1:0]    prv_wdata;
  logic                 lnk_we;
  logic [IDX_W-1:0]     lnk_waddr;
  logic [0:0]           lnk_wdata;

  assign key_ext     = 64'(in_key);
  assign node_ext    = 32'(in_node);
  assign node_bad_in = node_ext >= 32'(NODES);
  assign n_link      = LINK_W'(n_r);
  assign nxt_ok      = link_ok(nxt_q);
  assign a_link      = link_ok(prv_q);
  assign b_link      = link_ok(nxt_q);

  // read address: node under operation, or the walk cursor
  always_comb begin
    if (cmd.walk_start) begin
      raddr = head_first[IDX_W-1:0];
    end else if (cmd.walk_step) begin
      raddr = nxt_ok[IDX_W-1:0];
    end else begin
      raddr = n_r;
    end
  end

  always_comb begin
    nxt_we    = 1'b0;
    nxt_waddr = n_r;
    nxt_wdata = cur_r;
    prv_we    = 1'b0;
    prv_waddr = n_r;
    prv_wdata = at_r;
    lnk_we    = 1'b0;
    lnk_waddr = n_r;
    lnk_wdata = 1'b0;
    if (cmd.clr) begin
      lnk_we    = 1'b1;
      lnk_waddr = clr_cnt;
    end
    if (cmd.rm) begin
      nxt_we    = a_link != HEAD;
      nxt_waddr = a_link[IDX_W-1:0];
      nxt_wdata = b_link;
      prv_we    = b_link != HEAD;
      prv_waddr = b_link[IDX_W-1:0];
      prv_wdata = a_link;
      lnk_we    = 1'b1;
    end
    if (cmd.spl1) begin
      nxt_we    = 1'b1;
      prv_we    = 1'b1;
      lnk_we    = 1'b1;
      lnk_wdata = 1'b1;
    end
    if (cmd.spl2) begin
      nxt_we    = at_r != HEAD;
      nxt_waddr = at_r[IDX_W-1:0];
      nxt_wdata = n_link;
      prv_we    = cur_r != HEAD;
      prv_waddr = cur_r[IDX_W-1:0];
      prv_wdata = n_link;
    end
  end

  stl_ram #(.WIDTH(LINK_W), .DEPTH(NODES)) u_nxt_ram (
    .clk   (clk),
    .we    (nxt_we),
    .waddr (nxt_waddr),
    .wdata (nxt_wdata),
    .raddr (raddr),
    .rdata (nxt_q)
  );

  stl_ram #(.WIDTH(LINK_W), .DEPTH(NODES)) u_prv_ram (
    .clk   (clk),
    .we    (prv_we),
    .waddr (prv_waddr),
    .wdata (prv_wdata),
    .raddr (raddr),
    .rdata (prv_q)
  );

  stl_ram #(.WIDTH(KEY_WIDTH), .DEPTH(NODES)) u_key_ram (
    .clk   (clk),
    .we    (cmd.key_wr),
    .waddr (n_r),
    .wdata (key_r),
    .raddr (raddr),
    .rdata (key_q)
  );

  stl_ram #(.WIDTH(1), .DEPTH(NODES)) u_lnk_ram (
    .clk   (clk),
    .we    (lnk_we),
    .waddr (lnk_waddr),
    .wdata (lnk_wdata),
    .raddr (raddr),
    .rdata (lnk_q)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r       <= in_op;
      n_r        <= node_ext[IDX_W-1:0];
      node_bad_r <= node_bad_in;
      key_r      <= key_ext[KEY_WIDTH-1:0];
      status_r   <= (node_bad_in && in_op != OP_QUERY) ? ST_UNLINKED : ST_DONE;
    end else if (cmd.set_lnk) begin
      status_r <= ST_LINKED;
    end else if (cmd.set_unl) begin
      status_r <= ST_UNLINKED;
    end
    if (cmd.tail_set) begin
      at_r  <= head_last;
      cur_r <= HEAD;
    end else if (cmd.walk_start) begin
      at_r  <= HEAD;
      cur_r <= head_first;
    end else if (cmd.walk_step) begin
      at_r  <= cur_r;
      cur_r <= nxt_ok;
    end
    if (cmd.out_load) begin
      out_status <= status_r;
      out_empty  <= head_first == HEAD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_first <= HEAD;
      head_last  <= HEAD;
      clr_cnt    <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.clr) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (cmd.rm && a_link == HEAD) begin
        head_first <= b_link;
      end else if (cmd.spl2 && at_r == HEAD) begin
        head_first <= n_link;
      end
      if (cmd.rm && b_link == HEAD) begin
        head_last <= a_link;
      end else if (cmd.spl2 && cur_r == HEAD) begin
        head_last <= n_link;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    sts.is_query  = op_r == OP_QUERY;
    sts.node_bad  = node_bad_r;
    sts.is_remove = op_r == OP_REMOVE;
    sts.is_tail   = op_r == OP_TAIL || key_r == {KEY_WIDTH{1'b1}};
    sts.linked    = lnk_q[0];
    sts.walk_stop = cur_r == HEAD || key_q > key_r;
    sts.clr_last  = clr_cnt == IDX_W'(NODES - 1);
    sts.out_free  = !out_valid || out_ready;
  end

  `STL_ASSERT_IMP(a_spl_order, cmd.spl2, $past(cmd.spl1), "splice steps out of order")
  `STL_ASSERT_IMP(a_out_free, cmd.out_load, !out_valid || out_ready, "result overwritten")
  `STL_ASSERT_IMP(a_walk_self, cmd.walk_step, cur_r != n_link, "walk reached new node")
  `STL_ASSERT(a_rm_head, cmd.rm |=> head_first != n_link, "removed node still first")

endmodule

[rtl/sorted_timer_list_top.sv]
// ----------------------------------------------------------------------------
// Sorted timer list top level
// Key-ordered doubly linked list of NODES entries with sorted/tail insert,
// remove and empty query; one result beat per operation.
// ----------------------------------------------------------------------------
// channel   dir  tdata fields (low bit first)
// s_axis    in   op[1:0], node[6:2], key[38:7], pad[39]
// m_axis    out  status[1:0], list_empty[2], pad[7:3]
//
// A query or out-of-range node goes from lookup to the result; remove
// and insert of a linked node pass the check state; tail insert adds the
// splice states; sorted insert also walks, one step per entry passed (up to
// NODES-1) on the registered next-link RAM read. The next beat can be taken
// in the cycle after a result is loaded. After reset all linked flags are
// cleared; no beat is accepted meanwhile. Input is taken while a result waits
// in the output register; a held result stalls only the next completion.
// ----------------------------------------------------------------------------
module sorted_timer_list_top
  import stl_pkg::*;
#(
  parameter int NODES     = 32,
  parameter int KEY_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // op[1:0], node[6:2], key[38:7], zero[39]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata    // status[1:0], list_empty[2], zero[7:3]
);

  stl_cmd_t   cmd;
  stl_sts_t   sts;
  logic [1:0] out_status;
  logic       out_empty;

  stl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  stl_dp #(
    .NODES     (NODES),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .in_op      (s_tdata[1:0]),
    .in_node    (s_tdata[6:2]),
    .in_key     (s_tdata[38:7]),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_status (out_status),
    .out_empty  (out_empty)
  );

  assign m_tdata = {5'b0, out_empty, out_status};

endmodule

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// Sorted timer list testbench
// Drives list operations on the input stream and checks each status/empty
// beat against a local linked-list model. Directed cases cover ties, tail
// keys, out-of-order tail appends and rejected operations. A full-list fill
// with a drain pause follows, then random grow/shrink traffic with bursty
// idling on both sides and a final stretch with no idling.
// ----------------------------------------------------------------------------
module tb;
  import stl_pkg::*;

  localparam int          NODES      = 32;
  localparam logic [5:0]  HEAD       = 6'(NODES);
  localparam logic [31:0] KEY_ONES   = 32'hFFFF_FFFF;
  localparam int          IDLE_LIMIT = 3000;

  typedef struct {
    logic [1:0] status;
    logic       empty;
  } list_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;

  // list model state
  logic [5:0]  nxt_link [0:NODES];
  logic [5:0]  prv_link [0:NODES];
  logic [31:0] entry_key [0:NODES-1];
  bit          on_list [0:NODES-1];
  int          list_len;

  list_result_t expected_results[$];
  int           mismatches = 0;
  bit           quiet = 1'b0;
  int           tx_gap_pct = 20;
  int           rx_stall_pct = 20;
  int           rx_hold = 0;
  int           idle_cycles = 0;

  always #6 clk = ~clk;

  sorted_timer_list_top #(.NODES(NODES), .KEY_WIDTH(32)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  function automatic void clear_list();
    nxt_link[HEAD] = HEAD;
    prv_link[HEAD] = HEAD;
    for (int i = 0; i < NODES; i++) on_list[i] = 1'b0;
    list_len = 0;
  endfunction

  function automatic list_result_t apply_list_op(logic [1:0] op, logic [4:0] node,
                                                 logic [31:0] key);
    list_result_t r;
    logic [5:0]   at;
    logic [5:0]   nx;
    logic [5:0]   pv;
    int           steps;
    r.status = ST_DONE;
    if (op == OP_REMOVE) begin
      if (!on_list[node]) begin
        r.status = ST_UNLINKED;
      end else begin
        pv = prv_link[node];
        nx = nxt_link[node];
        nxt_link[pv] = nx;
        prv_link[nx] = pv;
        nxt_link[node] = 6'(node);
        prv_link[node] = 6'(node);
        on_list[node] = 1'b0;
        list_len--;
      end
    end else if (op != OP_QUERY) begin
      if (on_list[node]) begin
        r.status = ST_LINKED;
      end else begin
        entry_key[node] = key;
        if (op == OP_TAIL || key == KEY_ONES) begin
          at = prv_link[HEAD];
        end else begin
          // stop at the first entry with a larger key, or at the head
          at = HEAD;
          steps = 0;
          while (steps <= NODES) begin
            nx = nxt_link[at];
            if (nx == HEAD || entry_key[nx[4:0]] > key) break;
            at = nx;
            steps++;
          end
        end
        nx = nxt_link[at];
        nxt_link[node] = nx;
        prv_link[node] = at;
        nxt_link[at] = 6'(node);
        prv_link[nx] = 6'(node);
        on_list[node] = 1'b1;
        list_len++;
      end
    end
    r.empty = (nxt_link[HEAD] == HEAD);
    return r;
  endfunction

  function automatic logic [4:0] pick_node(bit want_linked);
    int start;
    start = $urandom_range(0, NODES - 1);
    for (int i = 0; i < NODES; i++) begin
      if (on_list[(start + i) % NODES] == want_linked) return 5'((start + i) % NODES);
    end
    return 5'(start);
  endfunction

  function automatic logic [31:0] rand_key();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return KEY_ONES;
      2:       return KEY_ONES - 1;
      3, 4, 5: return 32'($urandom_range(0, 15));
      default: return $urandom;
    endcase
  endfunction

  task automatic issue_op(input logic [1:0] op, input logic [4:0] node, input logic [31:0] key);
    if (!quiet && $urandom_range(1, 100) <= tx_gap_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, key, node, op};
    do @(posedge clk); while (!s_tready);
    expected_results.push_back(apply_list_op(op, node, key));
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // result checking and receiver stalls
  always @(posedge clk) begin
    list_result_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          $error("result beat with nothing expected: tdata=%h", m_tdata);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (m_tdata[1:0] !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, m_tdata[1:0]);
            mismatches++;
          end
          if (m_tdata[2] !== want.empty) begin
            $error("list_empty: expected %0d, got %0d", want.empty, m_tdata[2]);
            mismatches++;
          end
        end
      end
      if (rx_hold > 0) begin
        rx_hold--;
        m_tready <= 1'b0;
      end else if (!quiet && $urandom_range(1, 100) <= rx_stall_pct) begin
        rx_hold = $urandom_range(0, 2);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic test_reset();
    clear_list();
    rst <= 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
  endtask

  task automatic test_directed_ops();
    issue_op(OP_QUERY,  5'd0,  '0);
    issue_op(OP_REMOVE, 5'd0,  '0);           // not linked
    issue_op(OP_SORTED, 5'd5,  32'd100);
    issue_op(OP_SORTED, 5'd31, 32'd0);
    issue_op(OP_SORTED, 5'd0,  KEY_ONES);     // all-ones key goes to tail
    issue_op(OP_SORTED, 5'd7,  32'd100);      // tie lands after node 5
    issue_op(OP_SORTED, 5'd5,  32'd3);        // already linked
    issue_op(OP_TAIL,   5'd12, 32'd1);        // out of key order
    issue_op(OP_SORTED, 5'd13, 32'd50);
    issue_op(OP_SORTED, 5'd14, KEY_ONES - 1); // lands before the all-ones entry
    issue_op(OP_TAIL,   5'd12, 32'h5555_AAAA);
    issue_op(OP_SORTED, 5'd20, 32'd2);        // walk stops before the key-50 entry (node 13)
    issue_op(OP_REMOVE, 5'd7,  '0);
    issue_op(OP_REMOVE, 5'd7,  '0);
    issue_op(OP_REMOVE, 5'd31, '0);           // first entry
    issue_op(OP_REMOVE, 5'd20, '0);           // now the first entry
    issue_op(OP_QUERY,  5'd31, KEY_ONES);
    issue_op(OP_REMOVE, 5'd13, '0);
    issue_op(OP_REMOVE, 5'd5,  '0);
    issue_op(OP_REMOVE, 5'd14, '0);
    issue_op(OP_REMOVE, 5'd0,  '0);
    issue_op(OP_REMOVE, 5'd12, '0);
    issue_op(OP_QUERY,  5'd0,  '0);
  endtask

  // fill every slot with keys 0 to 7 so walks pass all entries of equal or smaller key, pause, then empty it
  task automatic test_full_list_with_pause();
    while (list_len < NODES) issue_op(OP_SORTED, pick_node(1'b0), 32'($urandom_range(0, 7)));
    issue_op(OP_SORTED, 5'($urandom_range(0, NODES - 1)), rand_key());
    wait_drained();
    issue_op(OP_QUERY, 5'd0, '0);
    while (list_len > 0) issue_op(OP_REMOVE, pick_node(1'b1), $urandom);
  endtask

  task automatic test_random_traffic(input int count);
    bit         grow;
    int         r;
    logic [1:0] op;
    logic [4:0] node;
    grow = 1'b1;
    for (int i = 0; i < count; i++) begin
      if (i % 100 == 0) begin
        case ($urandom_range(0, 2))
          0:       tx_gap_pct = 0;
          1:       tx_gap_pct = 15;
          default: tx_gap_pct = 40;
        endcase
        rx_stall_pct = 5 * $urandom_range(0, 6);
      end
      if (list_len == NODES) grow = 1'b0;
      if (list_len == 0) grow = 1'b1;
      r = $urandom_range(0, 99);
      if (r < (grow ? 50 : 15)) begin
        op = OP_SORTED;
      end else if (r < (grow ? 65 : 22)) begin
        op = OP_TAIL;
      end else if (r < 90) begin
        op = OP_REMOVE;
      end else if (r < 94) begin
        op = OP_QUERY;
      end else begin
        op = 2'($urandom_range(0, 2));  // broken: wrong link state
      end
      if (r >= 94) begin
        node = (op == OP_REMOVE) ? pick_node(1'b0) : pick_node(1'b1);
      end else if (op == OP_QUERY) begin
        node = 5'($urandom);
      end else if (op == OP_REMOVE) begin
        node = (list_len > 0) ? pick_node(1'b1) : pick_node(1'b0);
      end else begin
        node = (list_len < NODES) ? pick_node(1'b0) : pick_node(1'b1);
      end
      issue_op(op, node, rand_key());
    end
  endtask

  task automatic test_no_idling(input int count);
    quiet = 1'b1;
    test_random_traffic(count);
  endtask

  initial begin
    test_reset();
    test_directed_ops();
    test_full_list_with_pause();
    test_random_traffic(1050);
    test_no_idling(200);
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/stl_pkg.sv
rtl/stl_ram.sv
rtl/stl_ctrl.sv
rtl/stl_dp.sv
rtl/sorted_timer_list_top.sv
tb/sv/tb.sv
